// ===== rtl/jcrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcrm_pkg
// Shared codes and types of the journal commit replay matcher.
// ----------------------------------------------------------------------------
package jcrm_pkg;

  localparam int WORD_W = 32;
  localparam int DISC_W = 7;

  // record kinds on the input channel
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // result kinds on the output channel
  localparam logic RES_REPLAY  = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] block;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/journal_commit_replay_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_commit_replay_matcher
// Write-ahead-log replay matcher over a pending table held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries journal record headers in
//   log order. Output channel (out_valid_o / out_ready_i) carries replay
//   requests and the end-of-scan summary; last_o marks the final result of
//   an input request. cfg_valid_i / cfg_data_i writes expected_magic; it is
//   always ready. The user must write it only while the block is idle; the
//   block does not enforce this. Data, other and bad-magic records leave
//   the block idle. A commit walks the pending table through the table RAM's
//   single read port, one entry per cycle unless stalled, between a read
//   lead-in and a flush of the held match. Non-matching entries are written
//   back compacted in the same pass. End of scan passes through a summary
//   state. The latest match is held back so that last_o can be set; a further
//   match meeting a full output register and a stalled receiver pauses
//   the walk on that entry. Results leave through an output register, so
//   a new request is taken while the previous result still waits.
//   Reset clears the entry count, the stop flag and expected_magic; table
//   contents are not cleared and entries past the count are never read.
// ----------------------------------------------------------------------------
module journal_commit_replay_matcher
  import jcrm_pkg::*;
#(
  parameter int PENDING_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_data_i,
  // record headers
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [WORD_W-1:0] record_magic_i,
  input  logic [WORD_W-1:0] txn_seq_i,
  input  logic [WORD_W-1:0] dest_block_i,
  // results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              result_kind_o,
  output logic [WORD_W-1:0] replay_block_o,
  output logic [WORD_W-1:0] replay_seq_o,
  output logic [DISC_W-1:0] discarded_o,
  output logic              last_o
);

  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_SUM   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [WORD_W-1:0] magic_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              stopped_q, stopped_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [WORD_W-1:0] seq_q, seq_d;
  logic [CNT_W-1:0]  disc_q, disc_d;
  logic              hold_v_q, hold_v_d;
  entry_t            hold_q, hold_d;

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [WORD_W-1:0] out_block_q, out_block_d;
  logic [WORD_W-1:0] out_seq_q, out_seq_d;
  logic [DISC_W-1:0] out_disc_q, out_disc_d;
  logic              out_last_q, out_last_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  logic              in_acc, out_free, match, stall;
  logic [CNT_W-1:0]  idx_next;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign rd_entry    = entry_t'(ram_rdata);
  assign match       = (rd_entry.seq == seq_q);
  // a second match needs the held one pushed out first
  assign stall       = match && hold_v_q && !out_free;
  assign idx_next    = idx_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    seq_d       = seq_q;
    disc_d      = disc_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_block_d = out_block_q;
    out_seq_d   = out_seq_q;
    out_disc_d  = out_disc_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IDX_W-1:0];
    ram_wdata   = '{seq: txn_seq_i, block: dest_block_i};
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_END) begin
            disc_d    = count_q;
            count_d   = '0;
            stopped_d = 1'b0;
            state_d   = ST_SUM;
          end else if (!stopped_q) begin
            if (record_magic_i != magic_q) begin
              stopped_d = 1'b1;
            end else if (kind_i == KIND_DATA) begin
              if (count_q < CNT_W'(PENDING_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end else if (kind_i == KIND_COMMIT) begin
              if (count_q != '0) begin
                ram_re  = 1'b1;
                idx_d   = '0;
                kept_d  = '0;
                seq_d   = txn_seq_i;
                state_d = ST_SCAN;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (match) begin
            if (hold_v_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = RES_REPLAY;
              out_block_d = hold_q.block;
              out_seq_d   = hold_q.seq;
              out_disc_d  = '0;
              out_last_d  = 1'b0;
            end
            hold_v_d = 1'b1;
            hold_d   = rd_entry;
          end else begin
            // compaction: kept never passes the read index
            ram_we    = 1'b1;
            ram_waddr = kept_q[IDX_W-1:0];
            ram_wdata = rd_entry;
            kept_d    = kept_q + CNT_W'(1);
          end
          idx_d = idx_next;
          if (idx_next < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = idx_next[IDX_W-1:0];
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        count_d = kept_q;
        if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = RES_REPLAY;
          out_block_d = hold_q.block;
          out_seq_d   = hold_q.seq;
          out_disc_d  = '0;
          out_last_d  = 1'b1;
          hold_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = RES_SUMMARY;
          out_block_d = '0;
          out_seq_d   = '0;
          out_disc_d  = DISC_W'(disc_q);
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      magic_q     <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        magic_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    kept_q      <= kept_d;
    seq_q       <= seq_d;
    disc_q      <= disc_d;
    hold_q      <= hold_d;
    out_kind_q  <= out_kind_d;
    out_block_q <= out_block_d;
    out_seq_q   <= out_seq_d;
    out_disc_q  <= out_disc_d;
    out_last_q  <= out_last_d;
  end

  jcrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PENDING_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign replay_block_o = out_block_q;
  assign replay_seq_o   = out_seq_q;
  assign discarded_o    = out_disc_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/jcrm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcrm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module jcrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/jcrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcrm_checker
// Port-level assertions for the journal commit replay matcher.
// ----------------------------------------------------------------------------
module jcrm_checker
  import jcrm_pkg::*;
#(
  parameter int PENDING_DEPTH = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        kind_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              result_kind_o,
  input logic [WORD_W-1:0] replay_block_o,
  input logic [WORD_W-1:0] replay_seq_o,
  input logic [DISC_W-1:0] discarded_o,
  input logic              last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(replay_block_o)
      && $stable(replay_seq_o) && $stable(discarded_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_SUMMARY) |->
      last_o && (replay_block_o == '0) && (replay_seq_o == '0))
    else $error("summary result malformed");

  a_replay_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_REPLAY) |-> (discarded_o == '0))
    else $error("replay result carries a discard count");

  a_disc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (discarded_o <= DISC_W'(PENDING_DEPTH)))
    else $error("discard count beyond table depth");

  // end of scan blocks input until its summary is queued
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_END) |=> !in_ready_o)
    else $error("input taken right after end of scan");

endmodule

bind journal_commit_replay_matcher jcrm_checker #(
  .PENDING_DEPTH (PENDING_DEPTH)
) u_jcrm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .replay_block_o (replay_block_o),
  .replay_seq_o   (replay_seq_o),
  .discarded_o    (discarded_o),
  .last_o         (last_o)
);

// ===== verif/journal_replay_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_replay_checker
// Watches the configuration, record and result channels of the replay
// matcher. It keeps its own pending table, stop flag and magic, predicts the
// replay requests and summaries of every accepted record, and compares each
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module journal_replay_checker
  import jcrm_pkg::*;
#(
  parameter int PENDING_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        kind_i,
  input  logic [WORD_W-1:0] record_magic_i,
  input  logic [WORD_W-1:0] txn_seq_i,
  input  logic [WORD_W-1:0] dest_block_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              result_kind_i,
  input  logic [WORD_W-1:0] replay_block_i,
  input  logic [WORD_W-1:0] replay_seq_i,
  input  logic [DISC_W-1:0] discarded_i,
  input  logic              last_i,
  output int                error_count_o,
  output int                open_count_o
);

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] block;
    logic [WORD_W-1:0] seq;
    logic [DISC_W-1:0] discarded;
    logic              last;
  } replay_req_t;

  logic [WORD_W-1:0] live_magic;
  logic [WORD_W-1:0] pend_seq [PENDING_DEPTH];
  logic [WORD_W-1:0] pend_blk [PENDING_DEPTH];
  int                pend_count;
  logic              halted;
  replay_req_t       expected_replays [$];
  int                error_count = 0;
  int                open_count = 0;

  assign error_count_o = error_count;
  assign open_count_o  = open_count;

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    replay_req_t want;
    if (expected_replays.size() == 0) begin
      $display("%0t: unexpected result: kind %0d block %h seq %h discarded %0d last %0d",
               $time, result_kind_i, replay_block_i, replay_seq_i, discarded_i, last_i);
      error_count++;
    end else begin
      want = expected_replays.pop_front();
      compare_field("result_kind", WORD_W'(want.kind), WORD_W'(result_kind_i));
      compare_field("replay_block", want.block, replay_block_i);
      compare_field("replay_seq", want.seq, replay_seq_i);
      compare_field("discarded", WORD_W'(want.discarded), WORD_W'(discarded_i));
      compare_field("last", WORD_W'(want.last), WORD_W'(last_i));
    end
  endtask

  task automatic predict_record(input logic [1:0] kind, input logic [WORD_W-1:0] magic,
                                input logic [WORD_W-1:0] seq,
                                input logic [WORD_W-1:0] blk);
    replay_req_t req;
    int          kept = 0;
    int          hits = 0;
    // end of scan is never blocked and skips the magic check
    if (kind == KIND_END) begin
      req = '{kind: RES_SUMMARY, block: '0, seq: '0,
              discarded: DISC_W'(pend_count), last: 1'b1};
      expected_replays.push_back(req);
      pend_count = 0;
      halted = 1'b0;
      return;
    end
    if (halted) return;
    if (magic != live_magic) begin
      halted = 1'b1;
      return;
    end
    case (kind)
      KIND_DATA: begin
        if (pend_count < PENDING_DEPTH) begin
          pend_seq[pend_count] = seq;
          pend_blk[pend_count] = blk;
          pend_count++;
        end
      end
      KIND_COMMIT: begin
        for (int i = 0; i < pend_count; i++) begin
          if (pend_seq[i] == seq) begin
            req = '{kind: RES_REPLAY, block: pend_blk[i], seq: seq,
                    discarded: '0, last: 1'b0};
            expected_replays.push_back(req);
            hits++;
          end else begin
            pend_seq[kept] = pend_seq[i];
            pend_blk[kept] = pend_blk[i];
            kept++;
          end
        end
        pend_count = kept;
        if (hits > 0) expected_replays[expected_replays.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // results are checked before the same edge's record is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_magic = '0;
      pend_count = 0;
      halted = 1'b0;
      expected_replays.delete();
      open_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) live_magic = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        predict_record(kind_i, record_magic_i, txn_seq_i, dest_block_i);
      end
      open_count = expected_replays.size();
    end
  end

endmodule

// ===== verif/journal_commit_replay_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_commit_replay_matcher_test
// Drives journal record headers and magic writes into the replay matcher:
// a directed pass over the special cases, a back-pressure pass that fills
// the pending table, then randomized journal rounds under several idle and
// stall mixes. Checking is done by journal_replay_checker.
// ----------------------------------------------------------------------------
module journal_commit_replay_matcher_test;
  import jcrm_pkg::*;

  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam int ITEM_TARGET   = 410;
  localparam int TIMEOUT_NS    = 20_000_000;
  localparam logic [1:0] HEADER_KINDS [3] = '{KIND_DATA, KIND_COMMIT, KIND_OTHER};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [WORD_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i = KIND_OTHER;
  logic [WORD_W-1:0] record_magic_i = '0;
  logic [WORD_W-1:0] txn_seq_i = '0;
  logic [WORD_W-1:0] dest_block_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              result_kind_o;
  logic [WORD_W-1:0] replay_block_o;
  logic [WORD_W-1:0] replay_seq_o;
  logic [DISC_W-1:0] discarded_o;
  logic              last_o;

  int chk_errors;
  int chk_open;

  int                idle_pct = 0;
  int                stall_pct = 0;
  int                hold_requests = 0;
  int                holds_served = 0;
  int                hold_left = 0;
  int                items_sent = 0;
  logic [WORD_W-1:0] cur_magic = '0;

  journal_commit_replay_matcher uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .record_magic_i (record_magic_i),
    .txn_seq_i      (txn_seq_i),
    .dest_block_i   (dest_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .replay_block_o (replay_block_o),
    .replay_seq_o   (replay_seq_o),
    .discarded_o    (discarded_o),
    .last_o         (last_o)
  );

  journal_replay_checker replay_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .record_magic_i (record_magic_i),
    .txn_seq_i      (txn_seq_i),
    .dest_block_i   (dest_block_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_i  (result_kind_o),
    .replay_block_i (replay_block_o),
    .replay_seq_i   (replay_seq_o),
    .discarded_i    (discarded_o),
    .last_i         (last_o),
    .error_count_o  (chk_errors),
    .open_count_o   (chk_open)
  );

  always #10 clk_i = ~clk_i;

  // result receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left == 0 && holds_served != hold_requests) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[journal_commit_replay_matcher] ERROR");
    $finish;
  end

  task automatic send_record(input logic [1:0] kind, input logic [WORD_W-1:0] magic,
                             input logic [WORD_W-1:0] seq,
                             input logic [WORD_W-1:0] blk);
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    record_magic_i <= magic;
    txn_seq_i      <= seq;
    dest_block_i   <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  // sender pause: every expected result in, then room for a silent commit walk
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk_open != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_magic(input logic [WORD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_magic = value;
  endtask

  // one journal stretch: data records over a few sequence numbers, commits,
  // now and then a broken header or noise, usually closed by end of scan
  task automatic replay_round();
    logic [WORD_W-1:0] seq_pool [3];
    int                n_rec;
    int                roll;
    for (int j = 0; j < 3; j++) seq_pool[j] = $urandom;
    if ($urandom_range(4) == 0) seq_pool[0] = $urandom_range(1) ? '1 : '0;
    n_rec = $urandom_range(2, 12);
    repeat (n_rec) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        send_record(KIND_DATA, cur_magic, seq_pool[$urandom_range(2)],
                    $urandom_range(9) == 0 ? '1 : $urandom);
      end else if (roll < 78) begin
        send_record(KIND_COMMIT, cur_magic, seq_pool[$urandom_range(2)], $urandom);
      end else if (roll < 84) begin
        send_record(KIND_COMMIT, cur_magic, $urandom, $urandom);
      end else if (roll < 91) begin
        send_record(KIND_OTHER, cur_magic, $urandom, $urandom);
      end else if (roll < 93) begin
        send_record(HEADER_KINDS[$urandom_range(2)],
                    cur_magic ^ (32'h1 << $urandom_range(31)), $urandom, $urandom);
      end else begin
        send_record(2'($urandom), $urandom, $urandom, $urandom);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if ($urandom_range(99) < 60) send_record(KIND_COMMIT, cur_magic, seq_pool[j], $urandom);
    end
    if ($urandom_range(99) < 65) send_record(KIND_END, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [WORD_W-1:0] seq_a;
    logic [WORD_W-1:0] seq_b;
    int                idle_mix [4];
    int                stall_mix [4];
    logic [WORD_W-1:0] magic_mix [4];

    idle_mix  = '{0, 87, 0, 21};
    stall_mix = '{0, 0, 87, 21};
    magic_mix = '{'1, $urandom, '0, $urandom};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass, magic still at its reset value
    send_record(KIND_DATA, cur_magic, '0, '0);
    send_record(KIND_DATA, cur_magic, '1, '1);
    send_record(KIND_DATA, cur_magic, '0, 32'hA5A5_5A5A);
    send_record(KIND_OTHER, cur_magic, '1, '1);
    send_record(KIND_COMMIT, cur_magic, 32'h7, '0);
    send_record(KIND_COMMIT, cur_magic, '0, '1);
    send_record(KIND_COMMIT, cur_magic, '1, '0);
    send_record(KIND_END, '1, '0, '0);
    send_record(KIND_DATA, cur_magic, 32'h1, 32'h1);
    send_record(KIND_DATA, ~cur_magic, 32'h1, 32'h2);
    send_record(KIND_DATA, cur_magic, 32'h1, 32'h3);
    send_record(KIND_COMMIT, cur_magic, 32'h1, '0);
    send_record(KIND_END, cur_magic, '0, '0);
    send_record(KIND_DATA, cur_magic, 32'h3, 32'h4);
    send_record(KIND_OTHER, 32'h8000_0001, '0, '0);
    send_record(KIND_COMMIT, cur_magic, 32'h3, '0);
    send_record(KIND_END, cur_magic, '0, '0);
    send_record(KIND_DATA, cur_magic, 32'h5, 32'h6);
    send_record(KIND_COMMIT, cur_magic ^ 32'h1, 32'h5, '0);
    send_record(KIND_END, cur_magic, '0, '0);
    wait_for_drain();

    // back-pressure: overfill the table while results are held off
    write_magic(32'h5A5A_C3C3);
    seq_a = $urandom;
    seq_b = seq_a ^ 32'h1;
    hold_requests++;
    for (int k = 0; k < 66; k++) send_record(KIND_DATA, cur_magic, k[0] ? seq_b : seq_a, $urandom);
    send_record(KIND_COMMIT, cur_magic, seq_a, '0);
    repeat (3) send_record(KIND_DATA, cur_magic, seq_a, $urandom);
    send_record(KIND_COMMIT, cur_magic, seq_b, '0);
    send_record(KIND_END, cur_magic, '0, '0);
    wait_for_drain();
    repeat (65) send_record(KIND_DATA, cur_magic, $urandom, $urandom);
    send_record(KIND_END, cur_magic, '0, '0);
    wait_for_drain();

    for (int p = 0; p < 4; p++) begin
      write_magic(magic_mix[p]);
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      while (items_sent < 150 + (p + 1) * (ITEM_TARGET - 150) / 4) replay_round();
      wait_for_drain();
    end

    if (chk_errors == 0 && chk_open == 0) begin
      $display("[journal_commit_replay_matcher] OK");
    end else begin
      $display("[journal_commit_replay_matcher] ERROR");
    end
    $finish;
  end

endmodule

// ===== journal_commit_replay_matcher.f =====
rtl/jcrm_pkg.sv
rtl/jcrm_ram.sv
rtl/journal_commit_replay_matcher.sv
rtl/jcrm_checker.sv
verif/journal_replay_checker.sv
verif/journal_commit_replay_matcher_test.sv
